FILE: design/tbk_pkg.sv
// Package for the two-body kinematics block: widths, pipeline records,
// sine coefficients and the saturation helper. No dependencies.
package tbk_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int ANGLE_BITS   = 16;
    localparam int TRIG_FRAC    = 30;
    localparam int DIV_STEPS    = 32;
    localparam int SQRT_STEPS   = 32;
    localparam int HORNER_STEPS = 5;

    localparam logic [31:0] MINUS_ONE = 32'(-(64'sd1 <<< FRAC_BITS));
    localparam logic [30:0] TRIG_ONE  = 31'(64'd1 << TRIG_FRAC);

    // odd sine polynomial, Q1.30, lowest power first
    localparam logic [30:0] SINE_COEF [6] = '{
        31'd1686629713, 31'd693598669, 31'd85569292,
        31'd5026994, 31'd172272, 31'd3864
    };

    typedef enum logic [1:0] {
        REG_MASS_IN_A  = 2'd0,
        REG_MASS_IN_B  = 2'd1,
        REG_MASS_OUT_A = 2'd2,
        REG_MASS_OUT_B = 2'd3
    } reg_idx_t;

    // one particle pair as it moves down the row
    typedef struct packed {
        logic [31:0] ma;
        logic [63:0] msq;
        logic        swap;
        logic        ok;
        logic [31:0] rem;
        logic [31:0] dvd;
        logic [31:0] quo;
        logic [31:0] ea;
        logic [31:0] eb;
        logic [63:0] rad;
        logic [33:0] srem;
        logic [31:0] root;
    } lane_t;

    typedef struct packed {
        logic        vld;
        logic [31:0] e;
        logic [1:0]  quad;
        logic [30:0] u;
        logic [30:0] ts;
        logic [30:0] tc;
        logic [30:0] rs;
        logic [30:0] rc;
        logic [30:0] smag;
        logic [30:0] cmag;
        logic [33:0] ymag;
        logic [33:0] zmag;
        lane_t [1:0] lane;
    } stage_t;

    typedef struct packed {
        logic [31:0] energy;
        logic [31:0] py;
        logic [31:0] pz;
        logic        below;
    } result_t;

    // sign a magnitude and clamp to 32-bit two's complement
    function automatic logic [31:0] sat_signed(input logic neg, input logic [33:0] mag);
        logic [31:0] r;
        if (!neg)
            r = (mag > 34'h07FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
        else if (mag >= 34'h080000000)
            r = 32'h80000000;
        else
            r = 32'(-mag[31:0]);
        return r;
    endfunction

endpackage

FILE: design/tbk_if.sv
// Request channels of the kinematics block: input request and result request.
// Depends on tbk_pkg.
interface tbk_in_if import tbk_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [31:0] total_energy;
    logic [15:0] scatter_angle;

    modport source (output valid, total_energy, scatter_angle, input ready);
    modport sink   (input valid, total_energy, scatter_angle, output ready);
endinterface

interface tbk_out_if import tbk_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  particle_index;
    logic [31:0] particle_energy;
    logic [31:0] momentum_x;
    logic [31:0] momentum_y;
    logic [31:0] momentum_z;
    logic        below_threshold;
    logic        last_particle;

    modport source (output valid, particle_index, particle_energy, momentum_x,
                    momentum_y, momentum_z, below_threshold, last_particle,
                    input ready);
    modport sink   (input valid, particle_index, particle_energy, momentum_x,
                    momentum_y, momentum_z, below_threshold, last_particle,
                    output ready);
endinterface

FILE: design/tbk_div_cell.sv
// One restoring division step for both pairs: quotient bit by compare and
// subtract against the collision energy. Depends on tbk_pkg.
module tbk_div_cell import tbk_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  stage_t stage_in,
    output stage_t stage_out
);

    stage_t      q_reg, q_next;
    logic [32:0] rem_w [2];
    logic        ge [2];

    // shift in next dividend bit, subtract when it fits
    always_comb
    begin
        q_next = stage_in;
        for (int l = 0; l < 2; l++)
        begin
            rem_w[l] = {stage_in.lane[l].rem, stage_in.lane[l].dvd[31]};
            ge[l]    = rem_w[l] >= {1'b0, stage_in.e};
            q_next.lane[l].rem = ge[l] ? 32'(rem_w[l] - {1'b0, stage_in.e})
                                       : rem_w[l][31:0];
            q_next.lane[l].quo = {stage_in.lane[l].quo[30:0], ge[l]};
            q_next.lane[l].dvd = {stage_in.lane[l].dvd[30:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_reg.vld <= 1'b0;
        else if (en)
            q_reg <= q_next;
    end

    assign stage_out = q_reg;

endmodule

FILE: design/tbk_sqrt_cell.sv
// One digit of the integer square root for both pairs: two radicand bits
// per step. Depends on tbk_pkg.
module tbk_sqrt_cell import tbk_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  stage_t stage_in,
    output stage_t stage_out
);

    stage_t      q_reg, q_next;
    logic [35:0] rem_w [2];
    logic [35:0] trial [2];
    logic        ge [2];

    // trial subtract of 4*root+1
    always_comb
    begin
        q_next = stage_in;
        for (int l = 0; l < 2; l++)
        begin
            rem_w[l] = {stage_in.lane[l].srem, stage_in.lane[l].rad[63:62]};
            trial[l] = {2'b00, stage_in.lane[l].root, 2'b01};
            ge[l]    = rem_w[l] >= trial[l];
            q_next.lane[l].srem = ge[l] ? 34'(rem_w[l] - trial[l]) : rem_w[l][33:0];
            q_next.lane[l].root = {stage_in.lane[l].root[30:0], ge[l]};
            q_next.lane[l].rad  = {stage_in.lane[l].rad[61:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_reg.vld <= 1'b0;
        else if (en)
            q_reg <= q_next;
    end

    assign stage_out = q_reg;

endmodule

FILE: design/tbk_horner_cell.sv
// One Horner step of the sine polynomial for the sine and cosine arguments,
// truncating and floored at zero. Depends on tbk_pkg.
module tbk_horner_cell import tbk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic [30:0] coef,
    input  stage_t      stage_in,
    output stage_t      stage_out
);

    stage_t      q_reg, q_next;
    logic [61:0] prod_s, prod_c;
    logic [31:0] ds, dc;

    // r = coef - r*t
    always_comb
    begin
        q_next = stage_in;
        prod_s = {31'b0, stage_in.rs} * {31'b0, stage_in.ts};
        prod_c = {31'b0, stage_in.rc} * {31'b0, stage_in.tc};
        ds = prod_s[61:TRIG_FRAC];
        dc = prod_c[61:TRIG_FRAC];
        q_next.rs = ({1'b0, coef} > ds) ? 31'({1'b0, coef} - ds) : '0;
        q_next.rc = ({1'b0, coef} > dc) ? 31'({1'b0, coef} - dc) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_reg.vld <= 1'b0;
        else if (en)
            q_reg <= q_next;
    end

    assign stage_out = q_reg;

endmodule

FILE: design/two_body_cm_kinematics.sv
// Top level of the two-body center-of-mass kinematics block: mass registers,
// setup, energy, trig and scale stages around rows of cells, result serializer.
// Depends on tbk_pkg, tbk_if, tbk_div_cell, tbk_sqrt_cell, tbk_horner_cell.
//
//  channel   dir  request carries
//  in_ch     in   total_energy, scatter_angle
//  out_ch    out  particle_index, energies, momenta, flags (4 per input)
//  apb       in   four 32-bit mass registers at 0x0, 0x4, 0x8, 0xC
//
// A request passes a row of 73 registered stages (setup, 32 division cells,
// energy, 32 square root cells, 5 Horner cells, trig, scale), one step each.
// The serializer emits one result a cycle while the receiver is ready, four results per request.
// Reset clears valid bits and the serializer; no clearing pass.
// A waiting result stalls the row only when the row's last stage is full.
module two_body_cm_kinematics import tbk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tbk_in_if.sink      in_ch,
    tbk_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0] mass_in_a_reg, mass_in_b_reg, mass_out_a_reg, mass_out_b_reg;
    logic        en;

    // configuration registers
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mass_in_a_reg  <= '0;
            mass_in_b_reg  <= '0;
            mass_out_a_reg <= '0;
            mass_out_b_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_idx_t'(paddr[3:2]))
                REG_MASS_IN_A:  mass_in_a_reg  <= pwdata;
                REG_MASS_IN_B:  mass_in_b_reg  <= pwdata;
                REG_MASS_OUT_A: mass_out_a_reg <= pwdata;
                REG_MASS_OUT_B: mass_out_b_reg <= pwdata;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_MASS_IN_A:  prdata = mass_in_a_reg;
            REG_MASS_IN_B:  prdata = mass_in_b_reg;
            REG_MASS_OUT_A: prdata = mass_out_a_reg;
            REG_MASS_OUT_B: prdata = mass_out_b_reg;
        endcase
    end

    // setup stage: threshold, mass product, angle split
    stage_t      pre_reg, pre_next;
    logic [31:0] ma [2];
    logic [31:0] mb [2];
    logic [32:0] msum [2];
    logic [31:0] mdif [2];
    logic [64:0] prod [2];
    logic [ANGLE_BITS-1:0] ang;
    logic [30:0] uc;
    logic [61:0] usq, ucsq;

    always_comb
    begin
        ma[0] = mass_in_a_reg;
        mb[0] = mass_in_b_reg;
        ma[1] = mass_out_a_reg;
        mb[1] = mass_out_b_reg;
        pre_next = '0;
        pre_next.vld = in_ch.valid;
        pre_next.e   = in_ch.total_energy;
        for (int l = 0; l < 2; l++)
        begin
            msum[l] = {1'b0, ma[l]} + {1'b0, mb[l]};
            mdif[l] = (ma[l] < mb[l]) ? mb[l] - ma[l] : ma[l] - mb[l];
            prod[l] = {33'b0, mdif[l]} * {32'b0, msum[l]};
            pre_next.lane[l].ma   = ma[l];
            pre_next.lane[l].swap = ma[l] < mb[l];
            pre_next.lane[l].ok   = {1'b0, in_ch.total_energy} > msum[l];
            pre_next.lane[l].msq  = {32'b0, ma[l]} * {32'b0, ma[l]};
            pre_next.lane[l].rem  = pre_next.lane[l].ok ? prod[l][63:32] : '0;
            pre_next.lane[l].dvd  = pre_next.lane[l].ok ? prod[l][31:0] : '0;
        end
        ang  = in_ch.scatter_angle[ANGLE_BITS-1:0];
        pre_next.quad = ang[ANGLE_BITS-1:ANGLE_BITS-2];
        pre_next.u    = 31'(ang[ANGLE_BITS-3:0]) << (TRIG_FRAC - (ANGLE_BITS - 2));
        uc   = TRIG_ONE - pre_next.u;
        usq  = {31'b0, pre_next.u} * {31'b0, pre_next.u};
        ucsq = {31'b0, uc} * {31'b0, uc};
        pre_next.ts = usq[60:TRIG_FRAC];
        pre_next.tc = ucsq[60:TRIG_FRAC];
        pre_next.rs = SINE_COEF[HORNER_STEPS];
        pre_next.rc = SINE_COEF[HORNER_STEPS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pre_reg.vld <= 1'b0;
        else if (en)
            pre_reg <= pre_next;
    end

    assign in_ch.ready = en;

    // division row
    stage_t div_s [DIV_STEPS+1];
    assign div_s[0] = pre_reg;

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        tbk_div_cell u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .stage_in(div_s[k]), .stage_out(div_s[k+1])
        );
    end

    // energy stage: both energies and the radicand
    stage_t      eng_reg, eng_next;
    logic [32:0] e_ceil [2];
    logic [32:0] e_hi [2];
    logic [32:0] e_lo [2];
    logic [63:0] e_sq [2];

    always_comb
    begin
        eng_next = div_s[DIV_STEPS];
        for (int l = 0; l < 2; l++)
        begin
            e_ceil[l] = {1'b0, eng_next.lane[l].quo} + 33'(eng_next.lane[l].rem != '0);
            e_hi[l]   = ({1'b0, eng_next.e} + {1'b0, eng_next.lane[l].quo}) >> 1;
            e_lo[l]   = ({1'b0, eng_next.e} - e_ceil[l]) >> 1;
            eng_next.lane[l].ea = eng_next.lane[l].swap ? e_lo[l][31:0] : e_hi[l][31:0];
            eng_next.lane[l].eb = eng_next.lane[l].swap ? e_hi[l][31:0] : e_lo[l][31:0];
            e_sq[l] = {32'b0, eng_next.lane[l].ea} * {32'b0, eng_next.lane[l].ea};
            eng_next.lane[l].rad  = (eng_next.lane[l].ea >= eng_next.lane[l].ma)
                                    ? e_sq[l] - eng_next.lane[l].msq : '0;
            eng_next.lane[l].srem = '0;
            eng_next.lane[l].root = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eng_reg.vld <= 1'b0;
        else if (en)
            eng_reg <= eng_next;
    end

    // square root row
    stage_t sq_s [SQRT_STEPS+1];
    assign sq_s[0] = eng_reg;

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        tbk_sqrt_cell u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .stage_in(sq_s[k]), .stage_out(sq_s[k+1])
        );
    end

    // Horner row, highest remaining coefficient first
    stage_t hn_s [HORNER_STEPS+1];
    assign hn_s[0] = sq_s[SQRT_STEPS];

    for (genvar k = 0; k < HORNER_STEPS; k++)
    begin : g_horner
        tbk_horner_cell u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .coef(SINE_COEF[HORNER_STEPS-1-k]),
            .stage_in(hn_s[k]), .stage_out(hn_s[k+1])
        );
    end

    // trig stage: final multiply by u or 1-u, clamp, quadrant swap
    stage_t      trg_reg, trg_next;
    logic [30:0] t_uc;
    logic [61:0] t_ps, t_pc;
    logic [30:0] s0, c0;

    always_comb
    begin
        trg_next = hn_s[HORNER_STEPS];
        t_uc = TRIG_ONE - trg_next.u;
        t_ps = {31'b0, trg_next.rs} * {31'b0, trg_next.u};
        t_pc = {31'b0, trg_next.rc} * {31'b0, t_uc};
        s0 = (t_ps[61:TRIG_FRAC] > {1'b0, TRIG_ONE}) ? TRIG_ONE : t_ps[60:TRIG_FRAC];
        c0 = (t_pc[61:TRIG_FRAC] > {1'b0, TRIG_ONE}) ? TRIG_ONE : t_pc[60:TRIG_FRAC];
        trg_next.smag = trg_next.quad[0] ? c0 : s0;
        trg_next.cmag = trg_next.quad[0] ? s0 : c0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            trg_reg.vld <= 1'b0;
        else if (en)
            trg_reg <= trg_next;
    end

    // scale stage: outgoing momentum times trig, rounded
    stage_t      scl_reg, scl_next;
    logic [63:0] py_p, pz_p;

    always_comb
    begin
        scl_next = trg_reg;
        py_p = {32'b0, trg_reg.lane[1].root} * {33'b0, trg_reg.smag} + (64'd1 << 29);
        pz_p = {32'b0, trg_reg.lane[1].root} * {33'b0, trg_reg.cmag} + (64'd1 << 29);
        scl_next.ymag = py_p[63:TRIG_FRAC];
        scl_next.zmag = pz_p[63:TRIG_FRAC];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scl_reg.vld <= 1'b0;
        else if (en)
            scl_reg <= scl_next;
    end

    // result serializer
    result_t     res_reg [4];
    result_t     res_next [4];
    logic        busy_reg;
    logic [1:0]  idx_reg;
    logic        out_acc, freeing, load;
    logic        sin_neg, cos_neg;
    logic [33:0] p_in;

    assign out_acc = out_ch.valid && out_ch.ready;
    assign freeing = out_acc && (idx_reg == 2'd3);
    assign en      = !(scl_reg.vld && busy_reg && !freeing);
    assign load    = en && scl_reg.vld;

    always_comb
    begin
        sin_neg = scl_reg.quad[1];
        cos_neg = scl_reg.quad[1] ^ scl_reg.quad[0];
        p_in    = {2'b00, scl_reg.lane[0].root};
        for (int k = 0; k < 4; k++)
        begin
            res_next[k].energy = MINUS_ONE;
            res_next[k].py     = '0;
            res_next[k].pz     = '0;
            res_next[k].below  = 1'b1;
        end
        if (scl_reg.lane[0].ok)
        begin
            res_next[0] = '{sat_signed(1'b0, {2'b00, scl_reg.lane[0].ea}), '0,
                            sat_signed(1'b0, p_in), 1'b0};
            res_next[1] = '{sat_signed(1'b0, {2'b00, scl_reg.lane[0].eb}), '0,
                            sat_signed(1'b1, p_in), 1'b0};
        end
        if (scl_reg.lane[1].ok)
        begin
            res_next[2] = '{sat_signed(1'b0, {2'b00, scl_reg.lane[1].ea}),
                            sat_signed(!sin_neg, scl_reg.ymag),
                            sat_signed(cos_neg, scl_reg.zmag), 1'b0};
            res_next[3] = '{sat_signed(1'b0, {2'b00, scl_reg.lane[1].eb}),
                            sat_signed(sin_neg, scl_reg.ymag),
                            sat_signed(!cos_neg, scl_reg.zmag), 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (out_acc)
        begin
            if (idx_reg == 2'd3)
                busy_reg <= 1'b0;
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_next;
    end

    assign out_ch.valid           = busy_reg;
    assign out_ch.particle_index  = idx_reg;
    assign out_ch.particle_energy = res_reg[idx_reg].energy;
    assign out_ch.momentum_x      = '0;
    assign out_ch.momentum_y      = res_reg[idx_reg].py;
    assign out_ch.momentum_z      = res_reg[idx_reg].pz;
    assign out_ch.below_threshold = res_reg[idx_reg].below;
    assign out_ch.last_particle   = (idx_reg == 2'd3);

    // the row only stalls behind a full last stage and a busy serializer
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> (scl_reg.vld && busy_reg))
        else $error("row stalled without a blocked result");

    // a new bundle never overwrites results still owed
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!busy_reg || freeing))
        else $error("bundle loaded over pending results");

    // results of a bundle come out in order
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && idx_reg != 2'd3) |=> (busy_reg && idx_reg == $past(idx_reg) + 2'd1))
        else $error("particle index skipped");

    // the fourth result ends the bundle unless another is loaded
    a_bundle_end: assert property (@(posedge clk) disable iff (!rst_n)
        (freeing && !load) |=> !out_ch.valid)
        else $error("results continue after the last particle");

endmodule

FILE: tb/sv/two_body_cm_kinematics_tb.sv
// Testbench for two_body_cm_kinematics: random and directed energy/angle requests,
// mass register phases over APB, bit-exact prediction of the four particle results.
// Depends on tbk_pkg, tbk_if and the block's RTL.
`timescale 1ns / 1ps

module two_body_cm_kinematics_tb import tbk_pkg::*; ();

    localparam int LATENCY     = 80;
    localparam int WATCH_LIMIT = 20000;

    typedef struct {
        logic [31:0] energy;
        logic [15:0] angle;
    } kin_req_t;

    typedef struct {
        logic [1:0]  idx;
        logic [31:0] energy;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic        below;
        logic        last;
    } particle_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite, pready;
    logic [3:0]  paddr;
    logic [31:0] pwdata, prdata;

    tbk_in_if  in_ch ();
    tbk_out_if out_ch ();

    two_body_cm_kinematics DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor copy of the mass registers
    logic [63:0] masses [4];

    kin_req_t  pending_reqs [$];
    particle_t expected_particles [$];
    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  quiet_tail;
    int  hold_off = 0;
    bit  hold_done = 1'b0;
    int  phase_no = -1;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ---------------- predictor ----------------
    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic logic [63:0] energy_of(input logic [63:0] e, input logic [63:0] ms,
                                              input logic [63:0] mo);
        logic [63:0] sum, q, prod;
        sum = ms + mo;
        if (ms >= mo)
        begin
            q = ((ms - mo) * sum) / e;
            return (e + q) >> 1;
        end
        prod = (mo - ms) * sum;
        q = prod / e + ((prod % e) != 0 ? 64'd1 : 64'd0);
        if (q > e)
            return 0;
        return (e - q) >> 1;
    endfunction

    function automatic logic [63:0] sine_quarter(input logic [63:0] u);
        logic [63:0] t, r, d;
        logic [63:0] coef [6];
        coef = '{64'd1686629713, 64'd693598669, 64'd85569292, 64'd5026994,
                 64'd172272, 64'd3864};
        t = (u * u) >> 30;
        r = coef[5];
        for (int k = 4; k >= 0; k--)
        begin
            d = (r * t) >> 30;
            r = (coef[k] > d) ? coef[k] - d : 0;
        end
        r = (r * u) >> 30;
        return (r > (64'd1 << 30)) ? (64'd1 << 30) : r;
    endfunction

    function automatic logic [31:0] clamp_signed(input bit neg, input logic [63:0] mag);
        if (!neg)
            return (mag > 64'h7FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
        if (mag >= 64'h80000000)
            return 32'h80000000;
        return 32'(-mag[31:0]);
    endfunction

    task automatic predict_particles(input kin_req_t rq);
        logic [63:0] e, u, s0, c0, smag, cmag, ea, eb, p, ma, mb, ymag, zmag;
        logic [1:0]  quad;
        bit sneg, cneg, ok;
        particle_t pt;
        e    = rq.energy;
        quad = rq.angle[15:14];
        u    = 64'(rq.angle[13:0]) << 16;
        s0   = sine_quarter(u);
        c0   = sine_quarter((64'd1 << 30) - u);
        unique case (quad)
            2'd0: begin smag = s0; cmag = c0; sneg = 0; cneg = 0; end
            2'd1: begin smag = c0; cmag = s0; sneg = 0; cneg = 1; end
            2'd2: begin smag = s0; cmag = c0; sneg = 1; cneg = 1; end
            default: begin smag = c0; cmag = s0; sneg = 1; cneg = 0; end
        endcase
        for (int pair = 0; pair < 2; pair++)
        begin
            ma = masses[2*pair];
            mb = masses[2*pair+1];
            ok = (e != 0) && (e > ma + mb);
            for (int side = 0; side < 2; side++)
            begin
                pt.idx  = 2'(2*pair + side);
                pt.px   = 0;
                pt.last = (2*pair + side == 3);
                pt.below = !ok;
                if (!ok)
                begin
                    pt.energy = MINUS_ONE;
                    pt.py = 0;
                    pt.pz = 0;
                end
                else
                begin
                    ea = energy_of(e, ma, mb);
                    eb = energy_of(e, mb, ma);
                    p  = (ea >= ma) ? int_sqrt(ea * ea - ma * ma) : 0;
                    pt.energy = clamp_signed(0, side ? eb : ea);
                    if (pair == 0)
                    begin
                        pt.py = 0;
                        pt.pz = clamp_signed(side == 1, p);
                    end
                    else
                    begin
                        ymag = (p * smag + (64'd1 << 29)) >> 30;
                        zmag = (p * cmag + (64'd1 << 29)) >> 30;
                        pt.py = clamp_signed(side ? sneg : !sneg, ymag);
                        pt.pz = clamp_signed(side ? !cneg : cneg, zmag);
                    end
                end
                expected_particles.insert(expected_particles.size(), pt);
            end
        end
    endtask

    // ---------------- request driver ----------------
    // queue head is the request on the bus; it leaves the queue when accepted
    int src_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid         <= 1'b0;
            in_ch.total_energy  <= '0;
            in_ch.scatter_angle <= '0;
            src_gap             <= 0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (in_ch.valid)
                void'(pending_reqs.pop_front());
            if (src_gap > 0)
            begin
                src_gap     <= src_gap - 1;
                in_ch.valid <= 1'b0;
            end
            else if (pending_reqs.size() != 0)
            begin
                kin_req_t nx;
                nx = pending_reqs[0];
                in_ch.valid         <= 1'b1;
                in_ch.total_energy  <= nx.energy;
                in_ch.scatter_angle <= nx.angle;
                if (!quiet_tail && $urandom_range(0, 9) == 0)
                    src_gap <= $urandom_range(1, 18);
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // predict at acceptance
    always @(posedge clk)
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            kin_req_t rq;
            rq.energy = in_ch.total_energy;
            rq.angle  = in_ch.scatter_angle;
            predict_particles(rq);
        end

    // ---------------- result monitor ----------------
    int sink_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            sink_gap     <= 0;
        end
        else if (hold_off > 0)
            out_ch.ready <= 1'b0;
        else if (sink_gap > 0)
        begin
            sink_gap     <= sink_gap - 1;
            out_ch.ready <= 1'b0;
        end
        else if (!quiet_tail && $urandom_range(0, 11) == 0)
        begin
            sink_gap     <= $urandom_range(0, 17);
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    // long receiver hold-off, started once in the second random phase
    always @(posedge clk)
        if (rst_n)
        begin
            if (phase_no == 1 && !hold_done)
            begin
                hold_off  <= 400;
                hold_done <= 1'b1;
            end
            else if (hold_off > 0)
                hold_off <= hold_off - 1;
        end

    always @(posedge clk)
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            particle_t ex;
            if (expected_particles.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result particle %0d", out_ch.particle_index);
            end
            else
            begin
                ex = expected_particles.pop_front();
                if (out_ch.particle_index !== ex.idx || out_ch.particle_energy !== ex.energy
                    || out_ch.momentum_x !== ex.px || out_ch.momentum_y !== ex.py
                    || out_ch.momentum_z !== ex.pz || out_ch.below_threshold !== ex.below
                    || out_ch.last_particle !== ex.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp i=%0d e=%h x=%h y=%h z=%h b=%b l=%b",
                                 ex.idx, ex.energy, ex.px, ex.py, ex.pz, ex.below, ex.last,
                                 " | got i=%0d e=%h x=%h y=%h z=%h b=%b l=%b",
                                 out_ch.particle_index, out_ch.particle_energy,
                                 out_ch.momentum_x, out_ch.momentum_y, out_ch.momentum_z,
                                 out_ch.below_threshold, out_ch.last_particle);
                end
            end
        end

    // ---------------- watchdog ----------------
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("two_body_cm_kinematics verification failed");
            $finish;
        end
    end

    // ---------------- config and stimulus ----------------
    task automatic write_mass(input reg_idx_t r, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(r) << 2;
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        masses[r] = v;
    endtask

    task automatic drain_all();
        while (pending_reqs.size() != 0 || expected_particles.size() != 0 || in_ch.valid)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic add_req(input logic [31:0] e, input logic [15:0] a);
        kin_req_t rq;
        rq.energy = e;
        rq.angle  = a;
        pending_reqs.insert(pending_reqs.size(), rq);
    endtask

    // energy mostly near the thresholds, sometimes anything
    function automatic logic [31:0] pick_energy();
        logic [63:0] thr;
        thr = masses[0] + masses[1];
        if (masses[2] + masses[3] > thr && $urandom_range(0, 1))
            thr = masses[2] + masses[3];
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 3);
            2: return 32'(thr) + 32'($urandom_range(0, 2));
            3: return 32'(thr) - 32'($urandom_range(0, 2));
            default: return 32'(thr + $urandom_range(0, 32'h00400000));
        endcase
    endfunction

    function automatic logic [31:0] pick_mass();
        case ($urandom_range(0, 4))
            0: return 0;
            1: return $urandom;
            2: return 32'hFFFFFFFF;
            default: return $urandom_range(0, 32'h00100000);
        endcase
    endfunction

    initial
    begin
        psel <= 0; penable <= 0; pwrite <= 0; paddr <= 0; pwdata <= 0;
        quiet_tail = 0;
        for (int i = 0; i < 4; i++)
            masses[i] = 0;
        rst_n <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero masses: massless particles, all quadrants and angle extremes
        add_req(32'd0, 16'h0000);
        add_req(32'hFFFFFFFF, 16'hFFFF);
        add_req(32'h00010000, 16'h4000);
        add_req(32'h00010000, 16'h8000);
        add_req(32'h00010000, 16'hC000);
        add_req(32'h80000000, 16'h2AAA);
        add_req(32'd1, 16'h5555);
        drain_all();

        // unequal masses, at and just over threshold, saturated energies
        write_mass(REG_MASS_IN_A, 32'h00010000);
        write_mass(REG_MASS_IN_B, 32'h00030000);
        write_mass(REG_MASS_OUT_A, 32'h00050000);
        write_mass(REG_MASS_OUT_B, 32'h00000000);
        add_req(32'h00040000, 16'h1234);
        add_req(32'h00040001, 16'h1234);
        add_req(32'h00050000, 16'h9ABC);
        add_req(32'h00050001, 16'hE000);
        add_req(32'hFFFFFFFF, 16'h7FFF);
        add_req(32'h00000000, 16'h3FFF);
        drain_all();

        write_mass(REG_MASS_IN_A, 32'hFFFFFFFF);
        write_mass(REG_MASS_IN_B, 32'hFFFFFFFF);
        write_mass(REG_MASS_OUT_A, 32'h7FFFFFFF);
        write_mass(REG_MASS_OUT_B, 32'h80000000);
        add_req(32'hFFFFFFFF, 16'hFFFF);
        add_req(32'h00000001, 16'h0001);
        drain_all();

        // random phases with back-pressure stretch in the second one
        for (int ph = 0; ph < 6; ph++)
        begin
            write_mass(REG_MASS_IN_A, pick_mass());
            write_mass(REG_MASS_IN_B, pick_mass());
            write_mass(REG_MASS_OUT_A, pick_mass());
            write_mass(REG_MASS_OUT_B, pick_mass());
            if (ph == 5)
                quiet_tail = 1;
            phase_no = ph;
            for (int n = 0; n < 60; n++)
                add_req(pick_energy(), 16'($urandom));
            drain_all();
        end

        if (mismatches == 0 && expected_particles.size() == 0)
            $display("two_body_cm_kinematics verification clean");
        else
            $display("two_body_cm_kinematics verification failed");
        $finish;
    end

endmodule

FILE: files.f
design/tbk_pkg.sv
design/tbk_if.sv
design/tbk_div_cell.sv
design/tbk_sqrt_cell.sv
design/tbk_horner_cell.sv
design/two_body_cm_kinematics.sv
tb/sv/two_body_cm_kinematics_tb.sv
